### design/nsf_pkg.sv
// Shared types and constants for the NMEA sentence framer.
// No dependencies; the other files that use this package refer to it by scoped names.
`timescale 1ns / 1ps

package nsf_pkg;

  localparam logic [7:0] ChStart = 8'h24;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChNul   = 8'h00;

  // Back end hands a sentence bank back to the front end.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

### design/nmea_sentence_framer.sv
// NMEA 0183 sentence framer: top level with the descriptor queue between the
// front and back ends. Uses nsf_pkg, nsf_ram, nsf_front and nsf_back.
`timescale 1ns / 1ps

// Usage
//   Input queue: drive in_byte_i and push_i; a byte is taken on a rising edge
//   with push_i high and full_o low. Bytes before '$' are ignored; a sentence
//   runs from '$' to CR and is released by a following LF.
//   Result queue: while empty_o is low, out_byte_o/out_last_o hold the oldest
//   sentence character; pop_i takes it. out_last_o marks a sentence's end.
// Latency and throughput
//   The input takes one byte per cycle while full_o is low. A sentence's
//   first character passes the descriptor queue, a store RAM read and the
//   output queue once its LF is taken; then one character per cycle leaves
//   while pop_i stays high. The store holds two banks of STORE_DEPTH bytes.
//   full_o is high while the bank being filled still holds a sentence not yet
//   read out, i.e. when two finished sentences wait for the receiver.
// Reset
//   rst_ni clears parser state, the queues and bank ownership; store contents
//   are left as they are and need no clearing pass. A stalled receiver stops
//   the replay after four buffered characters and later backs up the input.

module nmea_sentence_framer #(
  parameter int STORE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] in_byte_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  localparam int FW = $clog2(STORE_DEPTH);
  localparam int AW = FW + 1;

  logic          accept;
  logic          wr_bank;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          dq_push, dq_push_bank;
  logic [FW-1:0] dq_push_len;
  logic          dq_pop;
  logic [1:0]    busy_q, busy_d;
  nsf_pkg::release_t rel;

  // descriptor queue: one entry per bank is enough
  logic          dq_bank_q [2];
  logic [FW-1:0] dq_len_q  [2];
  logic          dq_wp_q, dq_rp_q;
  logic [1:0]    dq_cnt_q;

  assign full_o = busy_q[wr_bank];
  assign accept = push_i && !full_o;

  nsf_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (in_byte_i),
    .bank_o      (wr_bank),
    .we_o        (ram_we),
    .waddr_o     (ram_waddr),
    .wdata_o     (ram_wdata),
    .desc_push_o (dq_push),
    .desc_bank_o (dq_push_bank),
    .desc_len_o  (dq_push_len)
  );

  nsf_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  nsf_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (dq_cnt_q != 2'd0),
    .desc_bank_i  (dq_bank_q[dq_rp_q]),
    .desc_len_i   (dq_len_q[dq_rp_q]),
    .desc_pop_o   (dq_pop),
    .re_o         (ram_re),
    .raddr_o      (ram_raddr),
    .rdata_i      (ram_rdata),
    .rel_o        (rel),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o)
  );

  always_comb begin
    busy_d = busy_q;
    if (rel.valid) begin
      busy_d[rel.bank] = 1'b0;
    end
    if (dq_push) begin
      busy_d[dq_push_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dq_push) begin
      dq_bank_q[dq_wp_q] <= dq_push_bank;
      dq_len_q[dq_wp_q]  <= dq_push_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= '0;
      dq_wp_q  <= 1'b0;
      dq_rp_q  <= 1'b0;
      dq_cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      if (dq_push) begin
        dq_wp_q <= ~dq_wp_q;
      end
      if (dq_pop) begin
        dq_rp_q <= ~dq_rp_q;
      end
      dq_cnt_q <= dq_cnt_q + 2'(dq_push) - 2'(dq_pop);
    end
  end

  // a descriptor never arrives at a full queue
  a_dq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dq_push |-> dq_cnt_q != 2'd2)
    else $error("descriptor queue overflow");

  // the front end never writes a bank that still waits for replay
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !busy_q[ram_waddr[AW-1]])
    else $error("write into a bank under replay");

  // only a bank that holds a sentence is handed back
  a_release_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel.valid |-> busy_q[rel.bank])
    else $error("release of a free bank");

  // replay reads only banks that hold a sentence
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> busy_q[ram_raddr[AW-1]])
    else $error("read from a free bank");

endmodule

### design/nsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### design/nsf_front.sv
// Front end: parses incoming bytes, writes sentence characters into the
// current store bank and posts a descriptor on CR LF. Uses nsf_pkg.
`timescale 1ns / 1ps

module nsf_front #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [7:0]                     byte_i,
  output logic                           bank_o,
  output logic                           we_o,
  output logic [$clog2(STORE_DEPTH):0]   waddr_o,
  output logic [7:0]                     wdata_o,
  output logic                           desc_push_o,
  output logic                           desc_bank_o,
  output logic [$clog2(STORE_DEPTH)-1:0] desc_len_o
);

  localparam int FW = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {
    PhIdle,
    PhCopy,
    PhWaitLf
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          bank_q, bank_d;

  always_comb begin
    phase_d     = phase_q;
    fill_d      = fill_q;
    bank_d      = bank_q;
    we_o        = 1'b0;
    waddr_o     = {bank_q, fill_q};
    wdata_o     = byte_i;
    desc_push_o = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        PhCopy: begin
          if (byte_i == nsf_pkg::ChCr) begin
            phase_d = PhWaitLf;
          end else if (byte_i == nsf_pkg::ChNul) begin
            phase_d = PhIdle;
            fill_d  = '0;
          end else if (byte_i == nsf_pkg::ChStart) begin
            // restart the sentence in place
            we_o    = 1'b1;
            waddr_o = {bank_q, {FW{1'b0}}};
            fill_d  = FW'(1);
          end else if (fill_q >= FW'(STORE_DEPTH - 1)) begin
            phase_d = PhIdle;
            fill_d  = '0;
          end else begin
            we_o   = 1'b1;
            fill_d = fill_q + FW'(1);
          end
        end
        PhWaitLf: begin
          if (byte_i == nsf_pkg::ChLf) begin
            desc_push_o = 1'b1;
            bank_d      = ~bank_q;
          end
          phase_d = PhIdle;
          fill_d  = '0;
        end
        default: begin
          if (byte_i == nsf_pkg::ChStart) begin
            we_o    = 1'b1;
            waddr_o = {bank_q, {FW{1'b0}}};
            fill_d  = FW'(1);
            phase_d = PhCopy;
          end
        end
      endcase
    end
  end

  assign bank_o      = bank_q;
  assign desc_bank_o = bank_q;
  assign desc_len_o  = fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      fill_q  <= '0;
      bank_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      bank_q  <= bank_d;
    end
  end

endmodule

### design/nsf_back.sv
// Back end: takes sentence descriptors, replays the stored bytes through an
// output queue with a last marker and frees the bank. Uses nsf_pkg.
`timescale 1ns / 1ps

module nsf_back #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           desc_valid_i,
  input  logic                           desc_bank_i,
  input  logic [$clog2(STORE_DEPTH)-1:0] desc_len_i,
  output logic                           desc_pop_o,
  output logic                           re_o,
  output logic [$clog2(STORE_DEPTH):0]   raddr_o,
  input  logic [7:0]                     rdata_i,
  output nsf_pkg::release_t              rel_o,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [7:0]                     out_byte_o,
  output logic                           out_last_o
);

  localparam int FW     = $clog2(STORE_DEPTH);
  localparam int QDepth = 4;
  localparam int QPw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 2);

  logic          active_q, active_d;
  logic          bank_q, bank_d;
  logic [FW-1:0] len_q, len_d;
  logic [FW-1:0] idx_q, idx_d;
  logic          pend_q, pend_last_q;
  logic          last_rd;

  logic [8:0]     oq_q [QDepth];
  logic [QPw-1:0] oq_wp_q, oq_rp_q;
  logic [QCw-1:0] oq_cnt_q;
  logic           oq_pop;

  assign desc_pop_o = !active_q && desc_valid_i;
  assign last_rd    = (idx_q == len_q - FW'(1));
  // issue a read only when the output queue has room for it and the one in flight
  assign re_o       = active_q && ((oq_cnt_q + QCw'(pend_q)) < QCw'(QDepth));
  assign raddr_o    = {bank_q, idx_q};
  assign rel_o.valid = re_o && last_rd;
  assign rel_o.bank  = bank_q;

  always_comb begin
    active_d = active_q;
    bank_d   = bank_q;
    len_d    = len_q;
    idx_d    = idx_q;
    if (desc_pop_o) begin
      active_d = 1'b1;
      bank_d   = desc_bank_i;
      len_d    = desc_len_i;
      idx_d    = '0;
    end else if (re_o) begin
      idx_d = idx_q + FW'(1);
      if (last_rd) begin
        active_d = 1'b0;
      end
    end
  end

  assign oq_pop     = pop_i && !empty_o;
  assign empty_o    = (oq_cnt_q == '0);
  assign out_byte_o = oq_q[oq_rp_q][8:1];
  assign out_last_o = oq_q[oq_rp_q][0];

  always_ff @(posedge clk_i) begin
    bank_q <= bank_d;
    len_q  <= len_d;
    idx_q  <= idx_d;
    if (pend_q) begin
      oq_q[oq_wp_q] <= {rdata_i, pend_last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      oq_wp_q     <= '0;
      oq_rp_q     <= '0;
      oq_cnt_q    <= '0;
    end else begin
      active_q    <= active_d;
      pend_q      <= re_o;
      pend_last_q <= last_rd;
      if (pend_q) begin
        oq_wp_q <= oq_wp_q + QPw'(1);
      end
      if (oq_pop) begin
        oq_rp_q <= oq_rp_q + QPw'(1);
      end
      oq_cnt_q <= oq_cnt_q + QCw'(pend_q) - QCw'(oq_pop);
    end
  end

endmodule

### sim/nsf_sentence_checker.sv
// Sentence checker for the NMEA sentence framer: watches both queue sides,
// predicts every emitted character from the pushed bytes and compares them.
// Uses nsf_pkg for the framing characters.
`timescale 1ns / 1ps

module nsf_sentence_checker #(
  parameter int STORE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] in_byte_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic [7:0] out_byte_i,
  input  logic       out_last_i,
  output int         errors_o,
  output int         pending_o,
  output int         chars_o,
  output int         sentences_o
);

  typedef enum logic [1:0] {
    HuntStart,
    CopyText,
    AwaitLf
  } hunt_phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } sentence_char_t;

  hunt_phase_e    phase;
  logic [5:0]     fill;
  logic [7:0]     text [64];
  sentence_char_t expected_chars [$];
  int             errors;
  int             chars;
  int             sentences;

  initial begin
    errors_o    = 0;
    pending_o   = 0;
    chars_o     = 0;
    sentences_o = 0;
    errors      = 0;
    chars       = 0;
    sentences   = 0;
    phase       = HuntStart;
    fill        = '0;
  end

  // Advance the framer state by one byte; queue the sentence on CR LF.
  task automatic frame_byte(input logic [7:0] b);
    int k;
    case (phase)
      CopyText: begin
        if (b == nsf_pkg::ChCr) begin
          phase = AwaitLf;
        end else if (b == nsf_pkg::ChNul) begin
          fill  = '0;
          phase = HuntStart;
        end else if (b == nsf_pkg::ChStart) begin
          text[0] = nsf_pkg::ChStart;
          fill    = 6'd1;
        end else if (int'(fill) >= STORE_DEPTH - 1) begin
          fill  = '0;
          phase = HuntStart;
        end else begin
          text[fill] = b;
          fill       = fill + 6'd1;
        end
      end
      AwaitLf: begin
        if (b == nsf_pkg::ChLf) begin
          for (k = 0; k < int'(fill); k++) begin
            expected_chars.push_back(sentence_char_t'{text[k], (k == int'(fill) - 1)});
          end
        end
        // Any other byte after CR is swallowed without a start check.
        fill  = '0;
        phase = HuntStart;
      end
      default: begin
        if (b == nsf_pkg::ChStart) begin
          text[0] = nsf_pkg::ChStart;
          fill    = 6'd1;
          phase   = CopyText;
        end
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    sentence_char_t want;
    if (!rst_ni) begin
      phase = HuntStart;
      fill  = '0;
      expected_chars.delete();
    end else begin
      // Pop side first: a result leaving now is older than any byte taken now.
      if (pop_i && !empty_i) begin
        chars++;
        if (out_last_i) sentences++;
        if (expected_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected character 8'h%02h last %0b with nothing expected",
                   $time, out_byte_i, out_last_i);
        end else begin
          want = expected_chars.pop_front();
          if (out_byte_i !== want.ch || out_last_i !== want.last) begin
            errors++;
            $display("%0t: character mismatch: expected 8'h%02h last %0b, got 8'h%02h last %0b",
                     $time, want.ch, want.last, out_byte_i, out_last_i);
          end
        end
      end
      if (push_i && !full_i) frame_byte(in_byte_i);
    end
    errors_o    <= errors;
    pending_o   <= expected_chars.size();
    chars_o     <= chars;
    sentences_o <= sentences;
  end

endmodule

### sim/nmea_sentence_framer_tb.sv
// Testbench top for the NMEA sentence framer: drives byte streams with bursty
// pushes and a patterned pop stall, and gives the verdict.
// Uses nsf_pkg, nmea_sentence_framer and nsf_sentence_checker.
`timescale 1ns / 1ps

module nmea_sentence_framer_tb;

  localparam int StoreDepth = 64;
  localparam int ItemGoal   = 170;
  localparam int StallLimit = 3000;

  typedef enum int {
    SentClean,
    SentNulAbort,
    SentRestart,
    SentCrDrop,
    SentNoisy
  } sentence_kind_e;

  typedef enum int {
    RxSteady,
    RxCoin,
    RxTrickle,
    RxHold
  } rx_mode_e;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       push     = 1'b0;
  logic [7:0] in_byte  = 8'h00;
  logic       pop      = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_last;

  int       errors;
  int       pending;
  int       chars_seen;
  int       sentences_seen;
  int       items_sent   = 0;
  int       noise_sent   = 0;
  int       burst_left   = 0;
  int       idle_streak  = 0;
  int       rx_left      = 0;
  int       kind_count [5];
  rx_mode_e rx_mode      = RxSteady;
  logic     draining     = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nmea_sentence_framer #(
    .STORE_DEPTH(StoreDepth)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .push_i    (push),
    .full_o    (full),
    .in_byte_i (in_byte),
    .empty_o   (empty),
    .pop_i     (pop),
    .out_byte_o(out_byte),
    .out_last_o(out_last)
  );

  nsf_sentence_checker #(
    .STORE_DEPTH(StoreDepth)
  ) checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push_i     (push),
    .full_i     (full),
    .in_byte_i  (in_byte),
    .empty_i    (empty),
    .pop_i      (pop),
    .out_byte_i (out_byte),
    .out_last_i (out_last),
    .errors_o   (errors),
    .pending_o  (pending),
    .chars_o    (chars_seen),
    .sentences_o(sentences_seen)
  );

  // Receiver: switch between steady, coin-flip, trickle and hold windows.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (draining) begin
      pop <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 60);
      end
      rx_left--;
      case (rx_mode)
        RxSteady:  pop <= 1'b1;
        RxCoin:    pop <= 1'($urandom_range(0, 1));
        RxTrickle: pop <= (rx_left % 4 == 0);
        default:   pop <= 1'b0;
      endcase
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_streak <= 0;
      end else if (idle_streak >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_streak <= idle_streak + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the byte is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push    <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (full);
    @(negedge clk);
    items_sent++;
  endtask

  // Sentence text: anything but the framing characters that end or restart it.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == nsf_pkg::ChCr || b == nsf_pkg::ChStart);
    return b;
  endfunction

  task automatic send_sentence(input sentence_kind_e kind, input int len);
    int         cut;
    int         i;
    logic [7:0] b;
    kind_count[kind]++;
    if (kind == SentNoisy) begin
      repeat ($urandom_range(1, 5)) begin
        send_byte(8'($urandom_range(0, 255)));
        noise_sent++;
      end
    end
    send_byte(nsf_pkg::ChStart);
    cut = $urandom_range(0, len);
    for (i = 0; i <= len; i++) begin
      if (i == cut && kind == SentNulAbort) send_byte(nsf_pkg::ChNul);
      if (i == cut && kind == SentRestart) send_byte(nsf_pkg::ChStart);
      if (i < len) send_byte(text_byte());
    end
    send_byte(nsf_pkg::ChCr);
    if (kind == SentCrDrop) begin
      do b = 8'($urandom_range(0, 255)); while (b == nsf_pkg::ChLf);
      send_byte(b);
    end else begin
      send_byte(nsf_pkg::ChLf);
    end
  endtask

  initial begin
    int             idx;
    int             len;
    int             pick;
    sentence_kind_e kind;

    foreach (kind_count[k]) kind_count[k] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: idle noise, byte extremes, abort, restart, drop, bare '$'.
    send_byte(8'hFF);
    send_byte(nsf_pkg::ChNul);
    send_byte(8'h41);
    send_byte(nsf_pkg::ChStart);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(nsf_pkg::ChCr);
    send_byte(nsf_pkg::ChLf);
    send_byte(nsf_pkg::ChStart);
    send_byte(8'h47);
    send_byte(nsf_pkg::ChNul);
    send_byte(nsf_pkg::ChStart);
    send_byte(8'h41);
    send_byte(nsf_pkg::ChStart);
    send_byte(8'h42);
    send_byte(nsf_pkg::ChCr);
    send_byte(nsf_pkg::ChLf);
    // A '$' right after CR is swallowed, so the LF that follows is ignored.
    send_byte(nsf_pkg::ChStart);
    send_byte(nsf_pkg::ChCr);
    send_byte(nsf_pkg::ChStart);
    send_byte(nsf_pkg::ChLf);
    send_byte(nsf_pkg::ChStart);
    send_byte(nsf_pkg::ChCr);
    send_byte(nsf_pkg::ChLf);

    // Random: mostly clean sentences, a few broken ones, rare long ones.
    idx = 0;
    while (items_sent < ItemGoal) begin
      idx++;
      if (idx == 2) begin
        send_sentence(SentClean, StoreDepth - 2);
      end else if (idx == 4) begin
        send_sentence(SentClean, StoreDepth - 1);
      end else begin
        len  = ($urandom_range(0, 14) == 0) ? $urandom_range(40, StoreDepth - 1)
                                            : $urandom_range(0, 12);
        pick = $urandom_range(0, 19);
        if (pick <= 12) kind = SentClean;
        else if (pick == 13) kind = SentNulAbort;
        else if (pick <= 15) kind = SentRestart;
        else if (pick <= 17) kind = SentCrDrop;
        else kind = SentNoisy;
        send_sentence(kind, len);
      end
    end
    push <= 1'b0;

    @(posedge clk);
    draining = 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Pushed %0d bytes: %0d clean, %0d NUL-aborted, %0d restarted, %0d CR-dropped",
             items_sent, kind_count[SentClean], kind_count[SentNulAbort],
             kind_count[SentRestart], kind_count[SentCrDrop]);
    $display("%0d sentences had %0d noise bytes; %0d characters in %0d sentences checked",
             kind_count[SentNoisy], noise_sent, chars_seen, sentences_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
